// File: sv/pkeg_pkg.sv
// shared types, codes and tables of the pad key event generator
package pkeg_pkg;

  // operation codes of an input item
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;

  // stick direction codes, none means centred
  localparam logic [2:0] DIR_UP    = 3'd0;
  localparam logic [2:0] DIR_DOWN  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_NONE  = 3'd4;

  // key codes
  localparam int unsigned KEY_COUNT = 11;
  localparam logic [3:0]  KEY_UP    = 4'd7;

  // raw button bits
  localparam int unsigned INTERCEPT_BIT = 31;

  // raw button mask of each mapped key, key order
  localparam logic [31:0] KEY_MASK [KEY_COUNT] = '{
    32'h0000_4000, 32'h0000_2000, 32'h0000_8000, 32'h0000_1000,
    32'h0000_0008, 32'h0000_0400, 32'h0000_0800, 32'h0000_0010,
    32'h0000_0040, 32'h0000_0080, 32'h0000_0020
  };

  // ring and register defaults
  localparam int unsigned RING_DEPTH_DEF = 64;
  localparam logic [15:0] REPEAT_DELAY_RST    = 16'd350;
  localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd110;
  localparam logic [7:0]  STICK_LOW_RST       = 8'd64;
  localparam logic [7:0]  STICK_HIGH_RST      = 8'd192;
  localparam logic [7:0]  DEAD_ZONE_RST       = 8'd64;

  // register indexes
  localparam logic [2:0] REG_REPEAT_DELAY    = 3'd0;
  localparam logic [2:0] REG_REPEAT_INTERVAL = 3'd1;
  localparam logic [2:0] REG_STICK_LOW       = 3'd2;
  localparam logic [2:0] REG_STICK_HIGH      = 3'd3;
  localparam logic [2:0] REG_DEAD_ZONE       = 3'd4;

  // configuration seen by front and back
  typedef struct packed {
    logic [15:0] repeat_delay_ms;
    logic [15:0] repeat_interval_ms;
    logic [7:0]  stick_low_limit;
    logic [7:0]  stick_high_limit;
    logic [7:0]  dead_zone;
  } cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] buttons;
    logic [2:0]  dir;
    logic [47:0] now_ms;
  } cmd_t;

  // time plus a delta, saturating at the largest time
  function automatic logic [47:0] time_add(input logic [47:0] now, input logic [15:0] delta);
    logic [48:0] sum;
    sum = {1'b0, now} + {33'd0, delta};
    return sum[48] ? {48{1'b1}} : sum[47:0];
  endfunction

endpackage

// File: sv/pad_key_event_generator.sv
// top level: configuration registers, front, item queue and back
// out_valid rises after the back passes these states. Sample: idle, one per mapped
// button, two for the stick, result load. Tick: idle, tick, result load. Pop:
// idle, ring read, event capture if one is found, result load. Unknown op: idle,
// result load. The back runs one item at a time; the queue takes two more.
// reset (synchronous, rst_n low) empties ring and queue, clears keys and stick, loads defaults
module pad_key_event_generator #(
  parameter int unsigned RING_DEPTH = pkeg_pkg::RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_button_word,
  input  logic [7:0]  in_stick_x,
  input  logic [7:0]  in_stick_y,
  input  logic        in_connected,
  input  logic [47:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_event_valid,
  output logic [3:0]  out_event_key,
  output logic        out_event_pressed,
  output logic [10:0] out_held_keys,
  output logic [5:0]  out_queued_events,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pkeg_pkg::cfg_t cfg_r, cfg_nxt;
  logic           cfg_wr;
  logic [2:0]     reg_idx;

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_not_empty;
  pkeg_pkg::cmd_t front_cmd;
  pkeg_pkg::cmd_t head_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        pkeg_pkg::REG_REPEAT_DELAY:    cfg_nxt.repeat_delay_ms    = pwdata[15:0];
        pkeg_pkg::REG_REPEAT_INTERVAL: cfg_nxt.repeat_interval_ms = pwdata[15:0];
        pkeg_pkg::REG_STICK_LOW:       cfg_nxt.stick_low_limit    = pwdata[7:0];
        pkeg_pkg::REG_STICK_HIGH:      cfg_nxt.stick_high_limit   = pwdata[7:0];
        pkeg_pkg::REG_DEAD_ZONE:       cfg_nxt.dead_zone          = pwdata[7:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_delay_ms    <= pkeg_pkg::REPEAT_DELAY_RST;
      cfg_r.repeat_interval_ms <= pkeg_pkg::REPEAT_INTERVAL_RST;
      cfg_r.stick_low_limit    <= pkeg_pkg::STICK_LOW_RST;
      cfg_r.stick_high_limit   <= pkeg_pkg::STICK_HIGH_RST;
      cfg_r.dead_zone          <= pkeg_pkg::DEAD_ZONE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register read mux
  always_comb begin
    unique case (reg_idx)
      pkeg_pkg::REG_REPEAT_DELAY:    prdata = {16'd0, cfg_r.repeat_delay_ms};
      pkeg_pkg::REG_REPEAT_INTERVAL: prdata = {16'd0, cfg_r.repeat_interval_ms};
      pkeg_pkg::REG_STICK_LOW:       prdata = {24'd0, cfg_r.stick_low_limit};
      pkeg_pkg::REG_STICK_HIGH:      prdata = {24'd0, cfg_r.stick_high_limit};
      pkeg_pkg::REG_DEAD_ZONE:       prdata = {24'd0, cfg_r.dead_zone};
      default:                       prdata = 32'd0;
    endcase
  end

  // accept and classify
  pkeg_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_button_word (in_button_word),
    .in_stick_x     (in_stick_x),
    .in_stick_y     (in_stick_y),
    .in_connected   (in_connected),
    .in_now_ms      (in_now_ms),
    .cfg            (cfg_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (front_cmd)
  );

  // queue between front and back
  pkeg_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // event sequencing and results
  pkeg_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_not_empty       (q_not_empty),
    .q_cmd             (head_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_valid   (out_event_valid),
    .out_event_key     (out_event_key),
    .out_event_pressed (out_event_pressed),
    .out_held_keys     (out_held_keys),
    .out_queued_events (out_queued_events)
  );

endmodule

// File: sv/pkeg_front.sv
// front part: accepts items and classifies buttons and stick
module pkeg_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  input  logic [31:0]          in_button_word,
  input  logic [7:0]           in_stick_x,
  input  logic [7:0]           in_stick_y,
  input  logic                 in_connected,
  input  logic [47:0]          in_now_ms,
  input  pkeg_pkg::cfg_t       cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output pkeg_pkg::cmd_t       q_cmd
);

  logic        neutral;
  logic [10:0] cur;
  logic [7:0]  h_off;
  logic [7:0]  v_off;
  logic [2:0]  dir;

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // mapped buttons, all released on a neutral sample
  always_comb begin
    neutral = !in_connected || in_button_word[pkeg_pkg::INTERCEPT_BIT];
    for (int k = 0; k < pkeg_pkg::KEY_COUNT; k++) begin
      cur[k] = !neutral && ((in_button_word & pkeg_pkg::KEY_MASK[k]) != 32'd0);
    end
  end

  // offsets from centre
  assign h_off = in_stick_x[7] ? {1'b0, in_stick_x[6:0]} : 8'd128 - in_stick_x;
  assign v_off = in_stick_y[7] ? {1'b0, in_stick_y[6:0]} : 8'd128 - in_stick_y;

  // stick direction with dead zone, vertical wins a tie
  always_comb begin
    dir = pkeg_pkg::DIR_NONE;
    if (neutral || (h_off < cfg.dead_zone && v_off < cfg.dead_zone)) begin
      dir = pkeg_pkg::DIR_NONE;
    end else if (h_off > v_off) begin
      if (in_stick_x < cfg.stick_low_limit) dir = pkeg_pkg::DIR_LEFT;
      else if (in_stick_x > cfg.stick_high_limit) dir = pkeg_pkg::DIR_RIGHT;
    end else begin
      if (in_stick_y < cfg.stick_low_limit) dir = pkeg_pkg::DIR_UP;
      else if (in_stick_y > cfg.stick_high_limit) dir = pkeg_pkg::DIR_DOWN;
    end
  end

  // classified item
  always_comb begin
    q_cmd.op      = in_operation;
    q_cmd.buttons = cur;
    q_cmd.dir     = dir;
    q_cmd.now_ms  = in_now_ms;
  end

endmodule

// File: sv/pkeg_cmd_q.sv
// two-entry queue of classified items between front and back
module pkeg_cmd_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pkeg_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output pkeg_pkg::cmd_t head_cmd
);

  pkeg_pkg::cmd_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign head_cmd  = slot_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: sv/pkeg_back.sv
// back part: event sequencer, event ring and result register
module pkeg_back #(
  parameter int unsigned RING_DEPTH = pkeg_pkg::RING_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pkeg_pkg::cfg_t cfg,
  input  logic           q_not_empty,
  input  pkeg_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_event_valid,
  output logic [3:0]     out_event_key,
  output logic           out_event_pressed,
  output logic [10:0]    out_held_keys,
  output logic [5:0]     out_queued_events
);

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = (PW > 6) ? PW : 6;
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BTN  = 3'd1;
  localparam logic [2:0] S_SREL = 3'd2;
  localparam logic [2:0] S_SPRS = 3'd3;
  localparam logic [2:0] S_TICK = 3'd4;
  localparam logic [2:0] S_POP  = 3'd5;
  localparam logic [2:0] S_POPD = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]     state_r, state_nxt;
  pkeg_pkg::cmd_t cmd_r, cmd_nxt;
  logic [3:0]     idx_r, idx_nxt;
  logic [10:0]    held_r, held_nxt;
  logic           active_r, active_nxt;
  logic [1:0]     skey_r, skey_nxt;
  logic [47:0]    due_r, due_nxt;
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic           ev_valid_r, ev_valid_nxt;
  logic [3:0]     ev_key_r, ev_key_nxt;
  logic           ev_pressed_r, ev_pressed_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_event_valid_r;
  logic [3:0]     out_event_key_r;
  logic           out_event_pressed_r;
  logic [10:0]    out_held_keys_r;
  logic [5:0]     out_queued_events_r;

  logic [4:0]     ring_mem [RING_DEPTH];
  logic [4:0]     rd_q_r;

  logic           push_en;
  logic [4:0]     push_data;
  logic [PW-1:0]  wp_inc;
  logic [PW-1:0]  rp_inc;
  logic           stick_change;
  logic           out_load;
  logic [CW-1:0]  count;

  // ring pointer increments with wrap
  assign wp_inc = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;

  // stick direction differs from the held one
  assign stick_change = cmd_r.dir != (active_r ? {1'b0, skey_r} : pkeg_pkg::DIR_NONE);

  // events in the ring
  always_comb begin
    if (wp_r >= rp_r) count = CW'(wp_r) - CW'(rp_r);
    else count = CW'(RING_DEPTH) - CW'(rp_r) + CW'(wp_r);
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    held_nxt       = held_r;
    active_nxt     = active_r;
    skey_nxt       = skey_r;
    due_nxt        = due_r;
    ev_valid_nxt   = ev_valid_r;
    ev_key_nxt     = ev_key_r;
    ev_pressed_nxt = ev_pressed_r;
    q_pop          = 1'b0;
    push_en        = 1'b0;
    push_data      = 5'd0;
    out_load       = 1'b0;
    rp_nxt         = rp_r;
    unique case (state_r)
      S_IDLE: begin
        ev_valid_nxt   = 1'b0;
        ev_key_nxt     = 4'd0;
        ev_pressed_nxt = 1'b0;
        if (q_not_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          idx_nxt = 4'd0;
          unique case (q_cmd.op)
            pkeg_pkg::OP_SAMPLE: state_nxt = S_BTN;
            pkeg_pkg::OP_TICK:   state_nxt = S_TICK;
            pkeg_pkg::OP_POP:    state_nxt = S_POP;
            default:             state_nxt = S_OUT;
          endcase
        end
      end
      S_BTN: begin
        // one button a cycle in key order
        if (cmd_r.buttons[idx_r] != held_r[idx_r]) begin
          push_en   = 1'b1;
          push_data = {cmd_r.buttons[idx_r], idx_r};
        end
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'(pkeg_pkg::KEY_COUNT - 1)) begin
          held_nxt  = cmd_r.buttons;
          state_nxt = S_SREL;
        end
      end
      S_SREL: begin
        // release of the old direction
        if (stick_change && active_r) begin
          push_en   = 1'b1;
          push_data = {1'b0, pkeg_pkg::KEY_UP + {2'b00, skey_r}};
        end
        state_nxt = S_SPRS;
      end
      S_SPRS: begin
        // press of the new direction and first repeat time
        if (stick_change) begin
          if (cmd_r.dir != pkeg_pkg::DIR_NONE) begin
            push_en    = 1'b1;
            push_data  = {1'b1, pkeg_pkg::KEY_UP + {2'b00, cmd_r.dir[1:0]}};
            active_nxt = 1'b1;
            skey_nxt   = cmd_r.dir[1:0];
            due_nxt    = pkeg_pkg::time_add(cmd_r.now_ms, cfg.repeat_delay_ms);
          end else begin
            active_nxt = 1'b0;
          end
        end
        state_nxt = S_OUT;
      end
      S_TICK: begin
        // repeat press once due
        if (active_r && cmd_r.now_ms >= due_r) begin
          push_en   = 1'b1;
          push_data = {1'b1, pkeg_pkg::KEY_UP + {2'b00, skey_r}};
          due_nxt   = pkeg_pkg::time_add(cmd_r.now_ms, cfg.repeat_interval_ms);
        end
        state_nxt = S_OUT;
      end
      S_POP: begin
        // ring read issued at the read pointer
        state_nxt = (rp_r != wp_r) ? S_POPD : S_OUT;
      end
      S_POPD: begin
        ev_valid_nxt   = 1'b1;
        ev_key_nxt     = rd_q_r[3:0];
        ev_pressed_nxt = rd_q_r[4];
        rp_nxt         = rp_inc;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // a push into a full ring drops the oldest event
    if (push_en && wp_inc == rp_r) begin
      rp_nxt = rp_inc;
    end
  end

  assign wp_nxt = push_en ? wp_inc : wp_r;

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= 11'd0;
      active_r    <= 1'b0;
      skey_r      <= 2'd0;
      due_r       <= 48'd0;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      active_r    <= active_nxt;
      skey_r      <= skey_nxt;
      due_r       <= due_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    ev_valid_r   <= ev_valid_nxt;
    ev_key_r     <= ev_key_nxt;
    ev_pressed_r <= ev_pressed_nxt;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_event_valid_r   <= ev_valid_r;
      out_event_key_r     <= ev_key_r;
      out_event_pressed_r <= ev_pressed_r;
      out_held_keys_r     <= held_r;
      out_queued_events_r <= count[5:0];
    end
  end

  // event ring memory with registered read
  always_ff @(posedge clk) begin
    if (push_en) begin
      ring_mem[wp_r] <= push_data;
    end
    rd_q_r <= ring_mem[rp_r];
  end

  assign out_valid         = out_valid_r;
  assign out_event_valid   = out_event_valid_r;
  assign out_event_key     = out_event_key_r;
  assign out_event_pressed = out_event_pressed_r;
  assign out_held_keys     = out_held_keys_r;
  assign out_queued_events = out_queued_events_r;

endmodule

// File: tb/tb_pad_key_event_generator.sv
// testbench for the pad key event generator: directed and random items checked against a predictor
`timescale 1ns / 100ps

module tb_pad_key_event_generator;

  localparam int unsigned RING_DEPTH    = pkeg_pkg::RING_DEPTH_DEF;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam logic [47:0] TIME_MAX      = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] INTERCEPT_MASK = 32'h8000_0000;
  localparam logic [31:0] ALL_BUTTONS   = 32'h0000_FCF8;

  // raw button bit of each key, key order
  localparam logic [31:0] BUTTON_BITS [11] = '{
    32'h0000_4000, 32'h0000_2000, 32'h0000_8000, 32'h0000_1000,
    32'h0000_0008, 32'h0000_0400, 32'h0000_0800, 32'h0000_0010,
    32'h0000_0040, 32'h0000_0080, 32'h0000_0020
  };

  localparam pkeg_pkg::cfg_t RESET_SETTING = '{16'd350, 16'd110, 8'd64, 8'd192, 8'd64};

  typedef struct packed {
    logic        event_valid;
    logic [3:0]  event_key;
    logic        event_pressed;
    logic [10:0] held_keys;
    logic [5:0]  queued_events;
  } key_report_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [31:0] in_button_word;
  logic [7:0]  in_stick_x;
  logic [7:0]  in_stick_y;
  logic        in_connected;
  logic [47:0] in_now_ms;
  logic        out_valid;
  logic        out_ready;
  logic        out_event_valid;
  logic [3:0]  out_event_key;
  logic        out_event_pressed;
  logic [10:0] out_held_keys;
  logic [5:0]  out_queued_events;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pad_key_event_generator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_button_word    (in_button_word),
    .in_stick_x        (in_stick_x),
    .in_stick_y        (in_stick_y),
    .in_connected      (in_connected),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_valid   (out_event_valid),
    .out_event_key     (out_event_key),
    .out_event_pressed (out_event_pressed),
    .out_held_keys     (out_held_keys),
    .out_queued_events (out_queued_events),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // predictor state and configuration copy
  logic [4:0]     ring_copy [RING_DEPTH];
  int unsigned    rd_idx;
  int unsigned    wr_idx;
  logic [10:0]    held_copy;
  logic           stick_on;
  logic [1:0]     stick_dir;
  logic [47:0]    repeat_due;
  pkeg_pkg::cfg_t cfg_copy;

  key_report_t pending_key_reports [$];
  int          fail_count = 0;
  int unsigned cycle_count = 0;

  // stimulus controls
  logic [47:0] clock_ms;
  logic [31:0] last_word;
  logic [7:0]  last_x;
  logic [7:0]  last_y;
  logic        last_conn;
  bit          source_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  int          hold_off_len = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic void reset_prediction();
    int i;
    for (i = 0; i < RING_DEPTH; i++) ring_copy[i] = '0;
    rd_idx = 0;
    wr_idx = 0;
    held_copy = '0;
    stick_on = 1'b0;
    stick_dir = '0;
    repeat_due = '0;
    cfg_copy = RESET_SETTING;
  endfunction

  function automatic int unsigned ring_step(input int unsigned p);
    return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
  endfunction

  // push one event, dropping the oldest when the ring is full
  function automatic void push_key_event(input logic [3:0] key, input logic pressed);
    int unsigned nxt;
    nxt = ring_step(wr_idx);
    if (nxt == rd_idx) rd_idx = ring_step(rd_idx);
    ring_copy[wr_idx] = {pressed, key};
    wr_idx = nxt;
  endfunction

  function automatic logic [5:0] ring_fill();
    int unsigned n;
    n = (wr_idx >= rd_idx) ? wr_idx - rd_idx : RING_DEPTH - rd_idx + wr_idx;
    return 6'(n);
  endfunction

  function automatic logic [47:0] due_after(input logic [47:0] now, input logic [15:0] delta);
    logic [48:0] total;
    total = 49'(now) + 49'(delta);
    if (total > 49'(TIME_MAX)) return TIME_MAX;
    return total[47:0];
  endfunction

  // stick direction with dead zone, vertical axis wins a tie
  function automatic logic [2:0] stick_heading(input logic [7:0] x, input logic [7:0] y);
    int h;
    int v;
    h = (x >= 8'd128) ? int'(x) - 128 : 128 - int'(x);
    v = (y >= 8'd128) ? int'(y) - 128 : 128 - int'(y);
    if (h < int'(cfg_copy.dead_zone) && v < int'(cfg_copy.dead_zone)) return pkeg_pkg::DIR_NONE;
    if (h > v) begin
      if (x < cfg_copy.stick_low_limit) return pkeg_pkg::DIR_LEFT;
      if (x > cfg_copy.stick_high_limit) return pkeg_pkg::DIR_RIGHT;
      return pkeg_pkg::DIR_NONE;
    end
    if (y < cfg_copy.stick_low_limit) return pkeg_pkg::DIR_UP;
    if (y > cfg_copy.stick_high_limit) return pkeg_pkg::DIR_DOWN;
    return pkeg_pkg::DIR_NONE;
  endfunction

  // expected result of one accepted item, updates the state copy
  function automatic key_report_t predict_key_report(input logic [1:0] op,
      input logic [31:0] word, input logic [7:0] x, input logic [7:0] y,
      input logic conn, input logic [47:0] now);
    key_report_t r;
    logic        neutral;
    logic [10:0] now_held;
    logic [10:0] changed;
    logic [2:0]  dir;
    logic [2:0]  old_dir;
    logic [4:0]  entry;
    int          k;
    r = '0;
    case (op)
      pkeg_pkg::OP_SAMPLE: begin
        neutral = !conn || ((word & INTERCEPT_MASK) != 0);
        now_held = '0;
        if (!neutral) begin
          for (k = 0; k < pkeg_pkg::KEY_COUNT; k++)
            if ((word & BUTTON_BITS[k]) != 0) now_held[k] = 1'b1;
        end
        changed = now_held ^ held_copy;
        for (k = 0; k < pkeg_pkg::KEY_COUNT; k++)
          if (changed[k]) push_key_event(4'(k), now_held[k]);
        held_copy = now_held;
        dir = neutral ? pkeg_pkg::DIR_NONE : stick_heading(x, y);
        old_dir = stick_on ? {1'b0, stick_dir} : pkeg_pkg::DIR_NONE;
        if (dir != old_dir) begin
          if (stick_on) push_key_event(pkeg_pkg::KEY_UP + 4'(stick_dir), 1'b0);
          if (dir != pkeg_pkg::DIR_NONE) begin
            stick_on = 1'b1;
            stick_dir = dir[1:0];
            push_key_event(pkeg_pkg::KEY_UP + 4'(dir), 1'b1);
            repeat_due = due_after(now, cfg_copy.repeat_delay_ms);
          end else begin
            stick_on = 1'b0;
          end
        end
      end
      pkeg_pkg::OP_TICK: begin
        if (stick_on && now >= repeat_due) begin
          push_key_event(pkeg_pkg::KEY_UP + 4'(stick_dir), 1'b1);
          repeat_due = due_after(now, cfg_copy.repeat_interval_ms);
        end
      end
      pkeg_pkg::OP_POP: begin
        if (rd_idx != wr_idx) begin
          entry = ring_copy[rd_idx];
          r.event_valid = 1'b1;
          r.event_key = entry[3:0];
          r.event_pressed = entry[4];
          rd_idx = ring_step(rd_idx);
        end
      end
      default: ;
    endcase
    r.held_keys = held_copy;
    r.queued_events = ring_fill();
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(input string name, input logic [10:0] want,
      input logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result receiver: random stalls plus an optional long hold-off
  initial begin : result_sink
    int stall_left;
    int n;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        n = hold_off_len;
        hold_off_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        if (stall_left == 0 && sink_stalls) stall_left = pick_gap();
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    key_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_key_reports.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        want = pending_key_reports.pop_front();
        check_field("event_valid", 11'(want.event_valid), 11'(out_event_valid));
        check_field("event_key", 11'(want.event_key), 11'(out_event_key));
        check_field("event_pressed", 11'(want.event_pressed), 11'(out_event_pressed));
        check_field("held_keys", want.held_keys, out_held_keys);
        check_field("queued_events", 11'(want.queued_events), 11'(out_queued_events));
      end
    end
  end

  // offer one item and record its prediction once accepted
  task automatic send_item(input logic [1:0] op, input logic [31:0] word,
      input logic [7:0] x, input logic [7:0] y, input logic conn, input logic [47:0] now);
    int gap;
    gap = source_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_button_word <= word;
    in_stick_x     <= x;
    in_stick_y     <= y;
    in_connected   <= conn;
    in_now_ms      <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_key_reports.push_back(predict_key_report(op, word, x, y, conn, now));
  endtask

  task automatic send_sample(input logic [31:0] word, input logic [7:0] x,
      input logic [7:0] y, input logic conn);
    last_word = word;
    last_x = x;
    last_y = y;
    last_conn = conn;
    send_item(pkeg_pkg::OP_SAMPLE, word, x, y, conn, clock_ms);
  endtask

  task automatic send_tick();
    send_item(pkeg_pkg::OP_TICK, $urandom(), 8'($urandom()), 8'($urandom()), 1'($urandom()),
              clock_ms);
  endtask

  task automatic send_pop();
    send_item(pkeg_pkg::OP_POP, $urandom(), 8'($urandom()), 8'($urandom()), 1'($urandom()),
              clock_ms);
  endtask

  // stop offering and wait until every expected result is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_key_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input pkeg_pkg::cfg_t c);
    wait_drain();
    write_register(pkeg_pkg::REG_REPEAT_DELAY, 32'(c.repeat_delay_ms));
    write_register(pkeg_pkg::REG_REPEAT_INTERVAL, 32'(c.repeat_interval_ms));
    write_register(pkeg_pkg::REG_STICK_LOW, 32'(c.stick_low_limit));
    write_register(pkeg_pkg::REG_STICK_HIGH, 32'(c.stick_high_limit));
    write_register(pkeg_pkg::REG_DEAD_ZONE, 32'(c.dead_zone));
    cfg_copy = c;
  endtask

  // pop on an empty ring and an unknown operation report status only
  task automatic test_status_only();
    send_pop();
    send_item(OP_UNUSED, $urandom(), 8'($urandom()), 8'($urandom()), 1'b1, clock_ms);
  endtask

  // press and release of every button, neutral samples
  task automatic test_button_edges();
    send_sample(ALL_BUTTONS, 8'd128, 8'd128, 1'b1);
    send_sample(32'h7FFF_FFFF, 8'd128, 8'd128, 1'b1);
    send_sample(32'hFFFF_FFFF, 8'd128, 8'd128, 1'b1);
    send_sample(32'h0000_4008, 8'd128, 8'd128, 1'b0);
    send_sample(32'h0000_4008, 8'd128, 8'd128, 1'b1);
    send_sample(32'h0000_0000, 8'd128, 8'd128, 1'b1);
  endtask

  // every stick direction, a tie on both axes, back to centre
  task automatic test_stick_directions();
    send_sample(32'h0, 8'd0, 8'd0, 1'b1);
    send_sample(32'h0, 8'd0, 8'd128, 1'b1);
    send_sample(32'h0, 8'd255, 8'd128, 1'b1);
    send_sample(32'h0, 8'd128, 8'd255, 1'b1);
    send_sample(32'h0, 8'd128, 8'd128, 1'b1);
  endtask

  // first repeat, later repeats, and a repeat time that saturates
  task automatic test_repeat_timing();
    clock_ms = 48'd1000;
    send_sample(32'h0, 8'd128, 8'd0, 1'b1);
    clock_ms = 48'd1349;
    send_tick();
    clock_ms = 48'd1350;
    send_tick();
    clock_ms = 48'd1460;
    send_tick();
    clock_ms = TIME_MAX - 48'd100;
    send_sample(32'h0, 8'd0, 8'd128, 1'b1);
    clock_ms = TIME_MAX - 48'd1;
    send_tick();
    clock_ms = TIME_MAX;
    send_tick();
    send_tick();
    clock_ms = 48'd2000;
  endtask

  // enough button events without pops to overrun the ring
  task automatic test_ring_overflow();
    int i;
    for (i = 0; i < 6; i++)
      send_sample((i % 2 == 0) ? ALL_BUTTONS : 32'h0, 8'd128, 8'd128, 1'b1);
  endtask

  // receiver holds off while items keep coming, then the sender waits
  task automatic test_backpressure();
    int i;
    source_gaps = 1'b0;
    hold_off_len = 300;
    for (i = 0; i < 40; i++)
      send_sample((i % 2 == 1) ? ALL_BUTTONS : 32'h0, 8'd128,
                  ((i / 2) % 2 == 1) ? 8'd0 : 8'd255, 1'b1);
    wait_drain();
    source_gaps = 1'b1;
  endtask

  // random mix of samples, ticks and pops with advancing time
  task automatic run_random_traffic(input int count, input int pop_pct);
    int          i;
    int          r;
    logic [31:0] word;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        conn;
    logic [63:0] wide;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < pop_pct) begin
        send_pop();
      end else if (r < pop_pct + 3) begin
        send_item(OP_UNUSED, $urandom(), 8'($urandom()), 8'($urandom()), 1'($urandom()),
                  clock_ms);
      end else if (r < pop_pct + 25) begin
        clock_ms += 48'($urandom_range(0, 250));
        send_tick();
      end else if ($urandom_range(0, 99) < 25) begin
        clock_ms += 48'($urandom_range(0, 40));
        send_sample(last_word, last_x, last_y, last_conn);
      end else begin
        case ($urandom_range(0, 9))
          0: word = $urandom();
          1: word = $urandom() | INTERCEPT_MASK;
          2, 3, 4: word = last_word ^ BUTTON_BITS[$urandom_range(0, pkeg_pkg::KEY_COUNT - 1)];
          default: word = $urandom() & ALL_BUTTONS;
        endcase
        conn = ($urandom_range(0, 19) != 0);
        case ($urandom_range(0, 7))
          0: begin
            x = 8'($urandom_range(100, 156));
            y = 8'($urandom_range(100, 156));
          end
          1: begin
            x = 8'($urandom_range(110, 146));
            y = 8'($urandom_range(0, 40));
          end
          2: begin
            x = 8'($urandom_range(110, 146));
            y = 8'($urandom_range(215, 255));
          end
          3: begin
            x = 8'($urandom_range(0, 40));
            y = 8'($urandom_range(110, 146));
          end
          4: begin
            x = 8'($urandom_range(215, 255));
            y = 8'($urandom_range(110, 146));
          end
          5, 6: begin
            x = last_x;
            y = last_y;
          end
          default: begin
            x = 8'($urandom());
            y = 8'($urandom());
          end
        endcase
        clock_ms += 48'($urandom_range(0, 40));
        send_sample(word, x, y, conn);
      end
      // rare jump to anywhere in the time range
      if ($urandom_range(0, 199) == 0) begin
        wide = {$urandom(), $urandom()};
        clock_ms = wide[47:0];
      end
    end
  endtask

  // several register settings, extremes among them, each with random traffic
  task automatic test_config_sweep();
    pkeg_pkg::cfg_t plan [7];
    int             i;
    plan[0] = RESET_SETTING;
    plan[1] = '{16'd0, 16'd0, 8'd64, 8'd192, 8'd64};
    plan[2] = '{16'd65535, 16'd65535, 8'd0, 8'd255, 8'd128};
    plan[3] = '{16'd20, 16'd5, 8'd255, 8'd0, 8'd0};
    plan[4] = '{16'd100, 16'd30, 8'd100, 8'd150, 8'd127};
    plan[5] = '{16'($urandom_range(0, 2000)), 16'($urandom_range(0, 500)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 128))};
    plan[6] = RESET_SETTING;
    for (i = 0; i < 7; i++) begin
      apply_config(plan[i]);
      // one phase runs with no idling on either side
      source_gaps = (i != 1) && ($urandom_range(0, 3) != 0);
      sink_stalls = (i != 1) && ($urandom_range(0, 3) != 0);
      run_random_traffic(240, (i % 2 == 1) ? 50 : 12);
    end
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  initial begin : test_sequence
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_operation   <= pkeg_pkg::OP_SAMPLE;
    in_button_word <= '0;
    in_stick_x     <= 8'd128;
    in_stick_y     <= 8'd128;
    in_connected   <= 1'b0;
    in_now_ms      <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    clock_ms = 48'd100;
    last_word = '0;
    last_x = 8'd128;
    last_y = 8'd128;
    last_conn = 1'b1;
    reset_prediction();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_status_only();
    test_button_edges();
    test_stick_directions();
    test_repeat_timing();
    test_ring_overflow();
    test_backpressure();
    test_config_sweep();

    wait_drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
